[rtl/itf_pkg.sv]
// Shared types, constants and helpers for the integer text formatter.
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;
  localparam int MAX_WIDTH    = 63;
  localparam int DIGIT_BUFFER = 32;   // octal of 64 bits needs 22 digits at most
  localparam int PREC_LIMIT   = 60;
  localparam int DIG_CNT_W    = 7;

  typedef enum logic [2:0] {
    OP_SDEC  = 3'd0,
    OP_UDEC  = 3'd1,
    OP_OCT   = 3'd2,
    OP_HEX   = 3'd3,
    OP_UHEX  = 3'd4,
    OP_PTR   = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PAD_LEFT,
    ST_SIGN,
    ST_PREFIX,
    ST_ZEROS,
    ST_DIGITS,
    ST_PAD_RIGHT
  } state_t;

  // Character source selected by the controller.
  typedef enum logic [2:0] {
    SRC_SPACE,
    SRC_ZERO,
    SRC_SIGN,
    SRC_PREFIX,
    SRC_DIGIT
  } src_t;

  typedef struct packed {
    logic        load;
    logic        conv_step;
    logic        emit;
    src_t        src;
    logic        last;
    logic        pfx_idx;
    logic [4:0]  dig_idx;
  } ctrl_t;

  typedef struct packed {
    logic        conv_done;
    logic [5:0]  pad_left;
    logic        has_sign;
    logic [1:0]  plen;
    logic [5:0]  zero_cnt;
    logic [6:0]  nd;
    logic [5:0]  pad_right;
  } stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) return 8'h30 + {4'd0, d};
    return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
  endfunction
endpackage
`default_nettype wire

[rtl/itf_datapath.sv]
// Datapath: operand capture, digit extraction, length arithmetic and character mux.
`timescale 1ns / 1ps
`default_nettype none
module itf_datapath (
  input  wire logic            clk,
  input  wire logic [2:0]      in_opcode,
  input  wire logic [63:0]     in_value,
  input  wire logic [4:0]      in_format_flags,
  input  wire logic [5:0]      in_field_width,
  input  wire logic [5:0]      in_min_digits,
  input  wire itf_pkg::ctrl_t  ctrl,
  output itf_pkg::stat_t       stat,
  output logic [7:0]           out_char
);
  logic [63:0] mag_r, mag_nxt;
  logic [1:0]  base_r;          // 0 dec, 1 oct, 2 hex
  logic        upper_r, left_r, zero_r, pfx_x_r;
  logic [7:0]  sign_r;
  logic        has_sign_r;
  logic [1:0]  plen_r;
  logic [5:0]  width_r, prec_r;
  logic [6:0]  nd_r;
  logic [3:0]  digs_r [itf_pkg::DIGIT_BUFFER];
  logic        done_r;

  // Decimal step: long division by ten, one byte of the operand per cycle;
  // after the last byte the remainder is stored as the next digit.
  logic [63:0] q_r;
  logic [3:0]  rem_r;
  logic [3:0]  bit_r;

  logic        neg;
  logic [2:0]  op;
  assign op  = in_opcode;
  assign neg = (op == itf_pkg::OP_SDEC) && in_value[63];

  // byte quotient via reciprocal: floor(x * 6554 / 2^16) = x / 10 for x < 2560
  logic [11:0] dec_num;
  logic [23:0] dec_prod;
  logic [7:0]  dec_q;
  logic [3:0]  dec_rem;
  assign dec_num  = {rem_r, mag_r[63:56]};
  assign dec_prod = {12'd0, dec_num} * 24'd6554;
  assign dec_q    = dec_prod[23:16];
  assign dec_rem  = 4'(dec_num - {1'b0, dec_q, 3'd0} - {3'd0, dec_q, 1'b0});

  assign mag_nxt = (base_r == 2'd1) ? (mag_r >> 3) : (mag_r >> 4);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      unique case (op)
        itf_pkg::OP_OCT:  base_r <= 2'd1;
        itf_pkg::OP_HEX, itf_pkg::OP_UHEX, itf_pkg::OP_PTR: base_r <= 2'd2;
        default: base_r <= 2'd0;
      endcase
      upper_r <= (op == itf_pkg::OP_UHEX);
      pfx_x_r <= (op == itf_pkg::OP_UHEX);
      left_r  <= in_format_flags[0];
      zero_r  <= !in_format_flags[0] && in_format_flags[1];
      mag_r   <= neg ? (~in_value + 64'd1) : in_value;
      has_sign_r <= (op == itf_pkg::OP_SDEC) &&
                    (in_value[63] || in_format_flags[2] || in_format_flags[3]);
      sign_r  <= in_value[63] ? 8'h2d : (in_format_flags[2] ? 8'h2b : 8'h20);
      if (op == itf_pkg::OP_PTR) plen_r <= 2'd2;
      else if (in_format_flags[4] &&
               (op == itf_pkg::OP_HEX || op == itf_pkg::OP_UHEX)) plen_r <= 2'd2;
      else if (in_format_flags[4] && op == itf_pkg::OP_OCT) plen_r <= 2'd1;
      else plen_r <= 2'd0;
      width_r <= in_field_width;
      prec_r  <= (in_min_digits > 6'(itf_pkg::PREC_LIMIT)) ?
                 6'(itf_pkg::PREC_LIMIT) : in_min_digits;
      nd_r    <= '0;
      done_r  <= 1'b0;
      rem_r   <= '0;
      bit_r   <= '0;
      q_r     <= '0;
    end else if (ctrl.conv_step && !done_r) begin
      if (base_r != 2'd0) begin
        digs_r[nd_r[4:0]] <= (base_r == 2'd1) ? {1'b0, mag_r[2:0]} : mag_r[3:0];
        nd_r <= nd_r + 7'd1;
        mag_r <= mag_nxt;
        if (mag_nxt == '0) done_r <= 1'b1;
      end else begin
        if (bit_r == 4'd8) begin
          digs_r[nd_r[4:0]] <= rem_r;
          nd_r  <= nd_r + 7'd1;
          mag_r <= q_r;
          bit_r <= '0;
          rem_r <= '0;
          q_r   <= '0;
          if (q_r == '0) done_r <= 1'b1;
        end else begin
          rem_r <= dec_rem;
          q_r   <= {q_r[55:0], dec_q};
          mag_r <= {mag_r[55:0], 8'd0};
          bit_r <= bit_r + 4'd1;
        end
      end
    end
  end

  // Length arithmetic
  logic [6:0] prec_eff, body, pad;
  assign prec_eff = ({1'b0, prec_r} < nd_r) ? nd_r : {1'b0, prec_r};
  assign body = {6'd0, has_sign_r} + {5'd0, plen_r} + prec_eff;
  assign pad  = ({1'b0, width_r} > body) ? ({1'b0, width_r} - body) : 7'd0;

  assign stat.conv_done = done_r;
  assign stat.has_sign  = has_sign_r;
  assign stat.plen      = plen_r;
  assign stat.nd        = nd_r;
  assign stat.pad_left  = (!left_r && !zero_r) ? pad[5:0] : 6'd0;
  assign stat.pad_right = left_r ? pad[5:0] : 6'd0;
  assign stat.zero_cnt  = 6'((zero_r ? pad : 7'd0) + (prec_eff - nd_r));

  always_comb begin
    unique case (ctrl.src)
      itf_pkg::SRC_SPACE:  out_char = 8'h20;
      itf_pkg::SRC_ZERO:   out_char = 8'h30;
      itf_pkg::SRC_SIGN:   out_char = sign_r;
      itf_pkg::SRC_PREFIX: out_char = (ctrl.pfx_idx && plen_r == 2'd2) ?
                                      (pfx_x_r ? 8'h58 : 8'h78) : 8'h30;
      itf_pkg::SRC_DIGIT:  out_char = itf_pkg::digit_char(digs_r[ctrl.dig_idx], upper_r);
      default:             out_char = 8'h20;
    endcase
  end
endmodule
`default_nettype wire

[rtl/itf_ctrl.sv]
// Controller: sequences conversion and the character emission phases.
`timescale 1ns / 1ps
`default_nettype none
module itf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire itf_pkg::stat_t stat,
  output itf_pkg::ctrl_t      ctrl
);
  itf_pkg::state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;   // characters left in current phase
  logic [5:0] total_r, total_nxt; // characters emitted

  logic [6:0] left_rem; // characters remaining after this one
  always_comb begin
    left_rem = 7'd0;
    unique case (state_r)
      itf_pkg::ST_PAD_LEFT:  left_rem = cnt_r - 7'd1 + {6'd0, stat.has_sign} +
          {5'd0, stat.plen} + {1'b0, stat.zero_cnt} + stat.nd;
      itf_pkg::ST_SIGN:      left_rem = {5'd0, stat.plen} + {1'b0, stat.zero_cnt} +
          stat.nd + {1'b0, stat.pad_right};
      itf_pkg::ST_PREFIX:    left_rem = cnt_r - 7'd1 + {1'b0, stat.zero_cnt} +
          stat.nd + {1'b0, stat.pad_right};
      itf_pkg::ST_ZEROS:     left_rem = cnt_r - 7'd1 + stat.nd + {1'b0, stat.pad_right};
      itf_pkg::ST_DIGITS:    left_rem = cnt_r - 7'd1 + {1'b0, stat.pad_right};
      itf_pkg::ST_PAD_RIGHT: left_rem = cnt_r - 7'd1;
      default:               left_rem = 7'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    ctrl      = '0;
    ctrl.src  = itf_pkg::SRC_SPACE;
    ctrl.pfx_idx = (stat.plen == 2'd2) && (cnt_r == 7'd1);
    ctrl.dig_idx = 5'(cnt_r - 7'd1);
    busy = (state_r != itf_pkg::ST_IDLE);
    if (state_r != itf_pkg::ST_IDLE && state_r != itf_pkg::ST_CONV) begin
      ctrl.emit = 1'b1;
      ctrl.last = (left_rem == 7'd0) || (total_r == 6'd62);
      total_nxt = total_r + 6'd1;
    end
    unique case (state_r)
      itf_pkg::ST_IDLE: if (start) begin
        ctrl.load = 1'b1;
        total_nxt = '0;
        state_nxt = itf_pkg::ST_CONV;
      end
      itf_pkg::ST_CONV: begin
        ctrl.conv_step = 1'b1;
        if (stat.conv_done) begin
          if (stat.pad_left != 0) begin
            state_nxt = itf_pkg::ST_PAD_LEFT; cnt_nxt = {1'b0, stat.pad_left};
          end else if (stat.has_sign) state_nxt = itf_pkg::ST_SIGN;
          else if (stat.plen != 0) begin
            state_nxt = itf_pkg::ST_PREFIX; cnt_nxt = {5'd0, stat.plen};
          end else if (stat.zero_cnt != 0) begin
            state_nxt = itf_pkg::ST_ZEROS; cnt_nxt = {1'b0, stat.zero_cnt};
          end else begin
            state_nxt = itf_pkg::ST_DIGITS; cnt_nxt = stat.nd;
          end
        end
      end
      itf_pkg::ST_PAD_LEFT, itf_pkg::ST_SIGN, itf_pkg::ST_PREFIX,
      itf_pkg::ST_ZEROS, itf_pkg::ST_DIGITS, itf_pkg::ST_PAD_RIGHT: begin
        unique case (state_r)
          itf_pkg::ST_SIGN:   ctrl.src = itf_pkg::SRC_SIGN;
          itf_pkg::ST_PREFIX: ctrl.src = itf_pkg::SRC_PREFIX;
          itf_pkg::ST_ZEROS:  ctrl.src = itf_pkg::SRC_ZERO;
          itf_pkg::ST_DIGITS: ctrl.src = itf_pkg::SRC_DIGIT;
          default:            ctrl.src = itf_pkg::SRC_SPACE;
        endcase
        cnt_nxt = cnt_r - 7'd1;
        if (ctrl.last) state_nxt = itf_pkg::ST_IDLE;
        else if (state_r == itf_pkg::ST_SIGN || cnt_r == 7'd1) begin
          // advance to the next non-empty phase
          if ((state_r == itf_pkg::ST_PAD_LEFT) && stat.has_sign)
            state_nxt = itf_pkg::ST_SIGN;
          else if ((state_r == itf_pkg::ST_PAD_LEFT || state_r == itf_pkg::ST_SIGN) &&
                   stat.plen != 0) begin
            state_nxt = itf_pkg::ST_PREFIX; cnt_nxt = {5'd0, stat.plen};
          end else if (state_r != itf_pkg::ST_ZEROS && state_r != itf_pkg::ST_DIGITS &&
                   stat.zero_cnt != 0) begin
            state_nxt = itf_pkg::ST_ZEROS; cnt_nxt = {1'b0, stat.zero_cnt};
          end else if (state_r != itf_pkg::ST_DIGITS) begin
            state_nxt = itf_pkg::ST_DIGITS; cnt_nxt = stat.nd;
          end else begin
            state_nxt = itf_pkg::ST_PAD_RIGHT; cnt_nxt = {1'b0, stat.pad_right};
          end
        end
      end
      default: state_nxt = itf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit && ctrl.last |=> state_r == itf_pkg::ST_IDLE) else $error("last without idle");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> !busy) else $error("load while busy");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit && total_r == 6'd62 |-> ctrl.last) else $error("over 63 chars");
`endif
endmodule
`default_nettype wire

[rtl/integer_text_formatter.sv]
// Top level of the integer text formatter.
// Digits are produced first: decimal by a byte-wise divide by ten (up to 20 digits),
// octal/hex by shifting, before the first character; then one character per cycle,
// up to 63.
// Throughput: one transaction at a time; busy stays high until the last character.
// Reset: synchronous active-low rst_n returns the controller to idle.
// Results cannot be stalled: out_valid marks each character for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module integer_text_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [63:0] in_value,
  input  wire logic [4:0]  in_format_flags,
  input  wire logic [5:0]  in_field_width,
  input  wire logic [5:0]  in_min_digits,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             out_last
);
  itf_pkg::ctrl_t ctrl;
  itf_pkg::stat_t stat;
  logic [7:0]     chr;

  itf_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .stat, .ctrl);
  itf_datapath u_dp (.clk, .in_opcode, .in_value, .in_format_flags, .in_field_width,
                     .in_min_digits, .ctrl, .stat, .out_char(chr));

  // Register the character stream.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= ctrl.emit;
    out_char <= chr;
    out_last <= ctrl.last;
  end
endmodule
`default_nettype wire

[dv/integer_text_formatter_tb.sv]
// Testbench for the integer text formatter: random and directed conversions checked per character.
`timescale 1ns / 1ps
module integer_text_formatter_tb;

  localparam logic [4:0] FL_LEFT  = 5'd1;
  localparam logic [4:0] FL_ZERO  = 5'd2;
  localparam logic [4:0] FL_PLUS  = 5'd4;
  localparam logic [4:0] FL_SPACE = 5'd8;
  localparam logic [4:0] FL_ALT   = 5'd16;

  // One pending conversion request.
  typedef struct {
    logic [2:0]  op;
    logic [63:0] val;
    logic [4:0]  flags;
    logic [5:0]  width;
    logic [5:0]  prec;
    int          gap;
    bit          drain;   // hold off until every expected character has come
  } conv_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [63:0] in_value;
  logic [4:0]  in_format_flags;
  logic [5:0]  in_field_width;
  logic [5:0]  in_min_digits;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  conv_req_t  req_q[$];
  text_char_t text_q[$];
  int         mismatches;
  bit         stim_done;

  integer_text_formatter u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_value(in_value), .in_format_flags(in_format_flags),
    .in_field_width(in_field_width), .in_min_digits(in_min_digits),
    .out_valid(out_valid), .out_char(out_char), .out_last(out_last)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic void push_char(logic [7:0] c);
    text_char_t t;
    t.ch = c;
    t.last = 1'b0;
    text_q.push_back(t);
  endfunction

  // Expected text for one conversion, appended to text_q.
  function automatic void format_text(conv_req_t r);
    logic [63:0] mag;
    logic [7:0]  digs[64];
    logic [7:0]  sign;
    logic [7:0]  pfx1;
    logic [3:0]  dv;
    int width, prec, base, nd, plen, pad, i, n0;
    bit left, zero, upper, has_sign;
    mag = r.val;
    width = r.width;
    prec = (r.prec > itf_pkg::PREC_LIMIT) ? itf_pkg::PREC_LIMIT : r.prec;
    base = 10;
    upper = 0;
    has_sign = 0;
    sign = " ";
    plen = 0;
    pfx1 = "x";
    nd = 0;
    n0 = text_q.size();
    case (r.op)
      itf_pkg::OP_OCT: base = 8;
      itf_pkg::OP_HEX, itf_pkg::OP_PTR: base = 16;
      itf_pkg::OP_UHEX: begin
        base = 16;
        upper = 1;
      end
      default: ;
    endcase
    left = r.flags[0];
    zero = !left && r.flags[1];
    if (r.op == itf_pkg::OP_SDEC) begin
      if (mag[63]) begin
        has_sign = 1; sign = "-"; mag = ~mag + 64'd1;
      end else if (r.flags & FL_PLUS) begin
        has_sign = 1; sign = "+";
      end else if (r.flags & FL_SPACE) begin
        has_sign = 1; sign = " ";
      end
    end
    if (r.op == itf_pkg::OP_PTR) plen = 2;
    else if (r.flags & FL_ALT) begin
      if (base == 16) begin
        plen = 2;
        pfx1 = upper ? "X" : "x";
      end else if (base == 8) plen = 1;
    end
    do begin
      dv = mag % base;
      digs[nd] = (dv < 10) ? 8'h30 + dv : (upper ? 8'h37 : 8'h57) + dv;
      nd++;
      mag = mag / base;
    end while (mag != 0);
    if (prec < nd) prec = nd;
    pad = width - (has_sign + plen + prec);
    if (pad < 0) pad = 0;
    if (!left && !zero) for (i = 0; i < pad; i++) push_char(" ");
    if (has_sign) push_char(sign);
    if (plen > 0) push_char("0");
    if (plen > 1) push_char(pfx1);
    if (zero) for (i = 0; i < pad; i++) push_char("0");
    for (i = nd; i < prec; i++) push_char("0");
    for (i = nd - 1; i >= 0; i--) push_char(digs[i]);
    if (left) for (i = 0; i < pad; i++) push_char(" ");
    // The text is capped at 63 characters.
    while (text_q.size() - n0 > 63) void'(text_q.pop_back());
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = v >> $urandom_range(0, 63);
      2: v = -($urandom_range(0, 1000));
      3: v = {1'b1, 63'd0} + $urandom_range(0, 2);
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_req(logic [2:0] op, logic [63:0] val, logic [4:0] fl,
                                  logic [5:0] w, logic [5:0] p);
    conv_req_t r;
    r.op = op; r.val = val; r.flags = fl; r.width = w; r.prec = p;
    r.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    r.drain = 0;
    req_q.push_back(r);
  endfunction

  // Driver: waits the item's gap, then raises start until the DUT accepts it.
  int        gap_cnt;
  conv_req_t cur;
  bit        have_cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      have_cur <= 0;
      gap_cnt <= 0;
    end else if (start && !busy) begin
      // transaction accepted at this edge
      format_text(cur);
      start <= 1'b0;
      have_cur <= 0;
    end else if (!start) begin
      if (!have_cur) begin
        if (req_q.size() > 0) begin
          cur = req_q.pop_front();
          have_cur <= 1;
          gap_cnt <= cur.gap;
        end else if (stim_done == 0 && rst_n) begin
          stim_done <= 1;
        end
      end else if (cur.drain && text_q.size() != 0) begin
        // hold off until the DUT has drained
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else begin
        start <= 1'b1;
        in_opcode <= cur.op;
        in_value <= cur.val;
        in_format_flags <= cur.flags;
        in_field_width <= cur.width;
        in_min_digits <= cur.prec;
      end
    end
  end

  // Monitor: every strobed character is checked against the oldest expectation.
  always @(posedge clk) begin
    text_char_t e;
    if (rst_n && out_valid) begin
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b", out_char, out_last);
      end else begin
        e = text_q.pop_front();
        if (e.ch !== out_char || e.last !== out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp char %h last %b, got char %h last %b",
                     e.ch, e.last, out_char, out_last);
        end
      end
    end
  end

  initial begin
    logic [2:0] op;
    int k, w;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_value = '0;
    in_format_flags = '0;
    in_field_width = '0;
    in_min_digits = '0;
    mismatches = 0;
    stim_done = 0;
    have_cur = 0;

    // Directed: every conversion, sign rules, extremes, padding corners.
    add_req(itf_pkg::OP_SDEC, 64'd0, 5'd0, 6'd0, 6'd0);
    add_req(itf_pkg::OP_SDEC, {1'b1, 63'd0}, 5'd0, 6'd0, 6'd0);
    add_req(itf_pkg::OP_SDEC, {1'b0, {63{1'b1}}}, FL_PLUS | FL_SPACE, 6'd30, 6'd0);
    add_req(itf_pkg::OP_SDEC, 64'd42, FL_SPACE, 6'd10, 6'd5);
    add_req(itf_pkg::OP_SDEC, -64'd7, FL_ZERO | FL_LEFT, 6'd8, 6'd0);
    add_req(itf_pkg::OP_SDEC, -64'd7, FL_ZERO | FL_PLUS, 6'd8, 6'd3);
    add_req(itf_pkg::OP_UDEC, '1, 5'd0, 6'd63, 6'd63);
    add_req(itf_pkg::OP_UDEC, 64'd0, FL_ALT, 6'd0, 6'd60);
    add_req(itf_pkg::OP_OCT, 64'd0, FL_ALT, 6'd5, 6'd0);
    add_req(itf_pkg::OP_OCT, '1, FL_ALT | FL_ZERO, 6'd63, 6'd0);
    add_req(itf_pkg::OP_HEX, 64'hdead_beef, FL_ALT | FL_LEFT, 6'd20, 6'd12);
    add_req(itf_pkg::OP_HEX, 64'd0, FL_ALT, 6'd0, 6'd0);
    add_req(itf_pkg::OP_UHEX, '1, FL_ALT | FL_ZERO, 6'd40, 6'd0);
    add_req(itf_pkg::OP_PTR, 64'hABC, 5'd0, 6'd0, 6'd0);
    add_req(itf_pkg::OP_PTR, 64'd0, FL_ALT | FL_PLUS, 6'd63, 6'd60);
    add_req(itf_pkg::OP_SDEC, -64'd1, 5'h1f, 6'd63, 6'd62);
    add_req(3'd6, 64'd123, 5'd0, 6'd4, 6'd0);
    add_req(3'd7, 64'd9, FL_ZERO, 6'd3, 6'd0);
    add_req(itf_pkg::OP_UHEX, 64'h1234_5678_9abc_def0, 5'd0, 6'd0, 6'd63);
    req_q[req_q.size() - 1].drain = 1;

    // Random: mostly narrow fields, a few wide ones.
    for (k = 0; k < 160; k++) begin
      op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 24);
      add_req(op, rand_value(), 5'($urandom_range(0, 31)), 6'(w),
              ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 12)));
      if (k == 80) req_q[req_q.size() - 1].drain = 1;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_done && text_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && text_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Worst case ~180 items of up to 20 decimal digits and 63 characters run about 1 ms;
  // the limit sits well above that.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
